// File: rtl/mmep_pkg.sv
// Shared types, constants and helper functions of the min/max envelope pyramid.
package mmep_pkg;

	localparam int MAX_CHANNELS    = 64;
	localparam int MAX_LOG2_LENGTH = 16;
	localparam int LEVELS          = MAX_LOG2_LENGTH - 1;

	localparam int DATA_W    = 32;
	localparam int ADDR_W    = 23;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;
	localparam int LG_W      = 5;
	localparam int CH_W      = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W     = $clog2(MAX_CHANNELS + 1);
	localparam int COL_W     = MAX_LOG2_LENGTH;
	localparam int PCOL_W    = MAX_LOG2_LENGTH + 2;
	localparam int LVL_W     = $clog2(LEVELS + 1);
	localparam int LIDX_W    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int ROW_W     = LEVELS * 2 * DATA_W;

	// queue between front and back, depth a power of two
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_COUNT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LOG2_LENGTH   = 1'b1;

	localparam logic [CFG_W-1:0] RST_CHANNEL_COUNT = CFG_W'(1);
	localparam logic [LG_W-1:0]  RST_LOG2_LENGTH   = LG_W'(10);

	typedef logic signed [DATA_W-1:0] sample_t;

	typedef struct packed {
		sample_t lo;
		sample_t hi;
	} pair_t;

	typedef pair_t [LEVELS-1:0] row_t;

	localparam pair_t RESET_PAIR = '{lo: 32'sh7FFF_FFFF, hi: 32'sh8000_0000};
	localparam row_t  RESET_ROW  = {LEVELS{RESET_PAIR}};

	// one closing sample: its position, the number of closed levels and their pairs
	typedef struct packed {
		logic [CH_W-1:0]  ch;
		logic [COL_W-1:0] col;
		logic [LVL_W-1:0] count;
		row_t             pairs;
	} job_t;

	// effective configuration after clamping
	typedef struct packed {
		logic [CNT_W-1:0] chans;
		logic [LG_W-1:0]  lg;
	} cfg_t;

	typedef enum logic {
		PH_MIN,
		PH_MAX
	} phase_t;

	function automatic logic [CNT_W-1:0] eff_chans(input logic [CFG_W-1:0] raw);
		logic [CNT_W-1:0] r;
		if (raw == '0)
			r = CNT_W'(1);
		else if (raw > CFG_W'(MAX_CHANNELS))
			r = CNT_W'(MAX_CHANNELS);
		else
			r = CNT_W'(raw);
		return r;
	endfunction

	function automatic logic [LG_W-1:0] eff_lg(input logic [LG_W-1:0] raw);
		logic [LG_W-1:0] r;
		if (raw < LG_W'(2))
			r = LG_W'(2);
		else if (raw > LG_W'(MAX_LOG2_LENGTH))
			r = LG_W'(MAX_LOG2_LENGTH);
		else
			r = raw;
		return r;
	endfunction

endpackage

// File: rtl/min_max_envelope_pyramid.sv
// A sample passes stage 1, the job queue and the output register before its first result beat.
// Throughput: one sample per cycle while the job queue has room; a sample closing k levels
//   yields 2k result beats, drained one per cycle while pop is held, so a long stream (about
//   two beats per sample) is limited by the drain; a closing sample stalls when queue full.
// Front and back are parted by a 2-entry job queue and a registered output beat.
// Reset: channel_count 1, log2_length 10, stream position zero; accumulators read empty
//   through per-channel valid bits, so there is no clearing pass.
module min_max_envelope_pyramid (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	output logic                           full,
	input  mmep_pkg::sample_t              sample,
	output logic                           empty,
	input  logic                           pop,
	output logic [mmep_pkg::ADDR_W-1:0]    address,
	output mmep_pkg::sample_t              value,
	output logic                           last_of_run,
	input  logic                           write_enable,
	input  logic [mmep_pkg::CFG_IDX_W-1:0] reg_index,
	input  logic [mmep_pkg::CFG_W-1:0]     write_data
);
	import mmep_pkg::*;

	logic [CFG_W-1:0] channel_count_q;
	logic [LG_W-1:0]  log2_length_q;
	cfg_t             cfg;
	job_t             job_in;
	job_t             job_out;
	logic             job_push;
	logic             job_full;
	logic             job_valid;
	logic             job_pop;

	// Hold the raw register values; clamp them for the datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= RST_CHANNEL_COUNT;
			log2_length_q   <= RST_LOG2_LENGTH;
		end else if (write_enable) begin
			if (reg_index == REG_CHANNEL_COUNT)
				channel_count_q <= write_data;
			else if (reg_index == REG_LOG2_LENGTH)
				log2_length_q <= write_data[LG_W-1:0];
		end
	end

	assign cfg = '{chans: eff_chans(channel_count_q), lg: eff_lg(log2_length_q)};

	// Front: any register write also drops the stream position and all accumulators.
	mmep_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.clear   (write_enable),
		.push    (push),
		.full    (full),
		.sample  (sample),
		.job     (job_in),
		.job_push(job_push),
		.job_full(job_full)
	);

	// Queue: decouples accumulation from the burst of emitted beats.
	mmep_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (job_push),
		.job_in (job_in),
		.full   (job_full),
		.pop    (job_pop),
		.job_out(job_out),
		.valid  (job_valid)
	);

	// Back: advance through the closed levels, min beat then max beat per level.
	mmep_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.job        (job_out),
		.job_valid  (job_valid),
		.job_pop    (job_pop),
		.empty      (empty),
		.pop        (pop),
		.address    (address),
		.value      (value),
		.last_of_run(last_of_run)
	);

endmodule

// File: rtl/mmep_ram.sv
// Generic single-write, single-read RAM with registered read data.
module mmep_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// File: rtl/mmep_queue.sv
// Short job queue between the accumulate front and the emit back.
module mmep_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mmep_pkg::job_t job_in,
	output logic          full,
	input  logic          pop,
	output mmep_pkg::job_t job_out,
	output logic          valid
);
	import mmep_pkg::*;

	job_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign full    = (count_q == QCNT_W'(QDEPTH));
	assign valid   = (count_q != '0);
	assign job_out = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			if (do_push && !do_pop)
				count_q <= count_q + QCNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - QCNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= job_in;
	end

endmodule

// File: rtl/mmep_front.sv
// Front end: accepts samples, updates per-channel level accumulators, queues closed blocks.
module mmep_front (
	input  logic            clk,
	input  logic            arst_n,
	input  mmep_pkg::cfg_t  cfg,
	input  logic            clear,
	input  logic            push,
	output logic            full,
	input  mmep_pkg::sample_t sample,
	output mmep_pkg::job_t  job,
	output logic            job_push,
	input  logic            job_full
);
	import mmep_pkg::*;

	logic [CH_W-1:0]         ch_q;
	logic [COL_W-1:0]        col_q;
	logic [MAX_CHANNELS-1:0] row_valid_q;
	logic                    valid_s1;
	logic                    rowok_s1;
	logic                    fwd_s1;
	sample_t                 sample_s1;
	logic [CH_W-1:0]         ch_s1;
	logic [COL_W-1:0]        col_s1;
	row_t                    row_last_q;

	logic             accept;
	logic             adv_s1;
	logic             wr_en;
	logic [ROW_W-1:0] ram_row;
	row_t             row_in;
	row_t             row_new;
	row_t             pair_out;
	logic [LVL_W-1:0] closed_cnt;
	logic [CNT_W-1:0] ch_nx;
	logic [COL_W-1:0] col_last;

	// accumulator rows, one per channel
	mmep_ram #(
		.WIDTH(ROW_W),
		.DEPTH(MAX_CHANNELS)
	) u_acc (
		.clk  (clk),
		.we   (wr_en),
		.waddr(ch_s1),
		.wdata(row_new),
		.re   (accept),
		.raddr(ch_q),
		.rdata(ram_row)
	);

	always_comb begin
		logic [COL_W-1:0] mask;
		pair_t            upd;
		if (fwd_s1)
			row_in = row_last_q;
		else if (rowok_s1)
			row_in = row_t'(ram_row);
		else
			row_in = RESET_ROW;
		closed_cnt = '0;
		for (int i = 0; i < LEVELS; i++) begin
			mask   = ~({COL_W{1'b1}} << (i + 1));
			upd.lo = ($signed(sample_s1) < $signed(row_in[i].lo)) ? sample_s1 : row_in[i].lo;
			upd.hi = ($signed(sample_s1) > $signed(row_in[i].hi)) ? sample_s1 : row_in[i].hi;
			pair_out[i] = upd;
			if ((LG_W'(i + 1) < cfg.lg) && ((col_s1 & mask) == mask)) begin
				row_new[i] = RESET_PAIR;
				closed_cnt = closed_cnt + LVL_W'(1);
			end else begin
				row_new[i] = upd;
			end
		end
	end

	// a closing sample waits in stage 1 until the queue has room
	assign adv_s1   = !valid_s1 || (closed_cnt == '0) || !job_full;
	assign full     = !adv_s1;
	assign accept   = push && !full;
	assign wr_en    = valid_s1 && adv_s1;
	assign job_push = valid_s1 && (closed_cnt != '0) && !job_full;
	assign job      = '{ch: ch_s1, col: col_s1, count: closed_cnt, pairs: pair_out};

	assign ch_nx    = CNT_W'(ch_q) + CNT_W'(1);
	assign col_last = ~({COL_W{1'b1}} << cfg.lg);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q        <= '0;
			col_q       <= '0;
			row_valid_q <= '0;
			valid_s1    <= 1'b0;
			rowok_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
		end else if (clear) begin
			ch_q        <= '0;
			col_q       <= '0;
			row_valid_q <= '0;
			valid_s1    <= 1'b0;
			rowok_s1    <= 1'b0;
			fwd_s1      <= 1'b0;
		end else begin
			if (wr_en)
				row_valid_q[ch_s1] <= 1'b1;
			if (accept) begin
				valid_s1 <= 1'b1;
				rowok_s1 <= row_valid_q[ch_q];
				// the row of the same channel is written at this edge: take it from the bypass
				fwd_s1   <= wr_en && (ch_s1 == ch_q);
				if (ch_nx >= cfg.chans) begin
					ch_q  <= '0;
					col_q <= (col_q == col_last) ? '0 : col_q + COL_W'(1);
				end else begin
					ch_q <= CH_W'(ch_nx);
				end
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
				fwd_s1   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1 <= sample;
			ch_s1     <= ch_q;
			col_s1    <= col_q;
		end
		if (wr_en)
			row_last_q <= row_new;
	end

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !clear |=> valid_s1)
		else $error("accepted sample did not enter stage 1");

	a_bypass_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> valid_s1)
		else $error("bypass flag set with empty stage 1");

	a_channel_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		CNT_W'(ch_q) < cfg.chans)
		else $error("channel counter beyond channel count");

	a_row_marked: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en && !clear |=> row_valid_q[$past(ch_s1)])
		else $error("written accumulator row not marked valid");

endmodule

// File: rtl/mmep_back.sv
// Back end: walks the closed levels of each queued job and emits min then max beats.
module mmep_back (
	input  logic            clk,
	input  logic            arst_n,
	input  mmep_pkg::cfg_t  cfg,
	input  mmep_pkg::job_t  job,
	input  logic            job_valid,
	output logic            job_pop,
	output logic            empty,
	input  logic            pop,
	output logic [mmep_pkg::ADDR_W-1:0] address,
	output mmep_pkg::sample_t value,
	output logic            last_of_run
);
	import mmep_pkg::*;

	localparam int SH_W   = LG_W + 1;
	localparam int PROD_W = PCOL_W + CNT_W;

	phase_t             phase_q;
	phase_t             phase_d;
	logic [LIDX_W-1:0]  lvl_q;
	logic [LIDX_W-1:0]  lvl_d;
	logic [ADDR_W-1:0]  amin_q;
	logic               out_valid_q;
	logic [ADDR_W-1:0]  address_q;
	sample_t            value_q;
	logic               last_q;

	logic               step;
	logic               is_last;
	logic [SH_W-1:0]    j_sh;
	logic [PCOL_W-1:0]  start;
	logic [COL_W-1:0]   colsh;
	logic [PCOL_W-1:0]  pcol;
	logic [PROD_W-1:0]  prod;
	logic [ADDR_W-1:0]  a_min;
	logic [ADDR_W-1:0]  res_addr;
	sample_t            res_value;
	logic               res_last;
	pair_t              pair;

	assign empty       = !out_valid_q;
	assign address     = address_q;
	assign value       = value_q;
	assign last_of_run = last_q;

	assign step    = job_valid && (!out_valid_q || pop);
	assign is_last = (LVL_W'(lvl_q) + LVL_W'(1)) == job.count;
	assign job_pop = step && (phase_q == PH_MAX) && is_last;

	// next state of the emit sequencer
	always_comb begin
		phase_d = phase_q;
		lvl_d   = lvl_q;
		unique case (phase_q)
			PH_MIN: begin
				phase_d = PH_MAX;
			end
			PH_MAX: begin
				phase_d = PH_MIN;
				lvl_d   = is_last ? '0 : lvl_q + LIDX_W'(1);
			end
			default: begin
				phase_d = PH_MIN;
				lvl_d   = '0;
			end
		endcase
	end

	// address and value of the beat the sequencer produces
	always_comb begin
		j_sh  = SH_W'(lvl_q) + SH_W'(1);
		start = (PCOL_W'(1) << (SH_W'(cfg.lg) + SH_W'(1)))
			- (PCOL_W'(1) << (SH_W'(cfg.lg) + SH_W'(2) - j_sh));
		colsh = job.col >> j_sh;
		pcol  = start + PCOL_W'({colsh, 1'b0});
		prod  = PROD_W'(pcol) * PROD_W'(cfg.chans);
		a_min = ADDR_W'(prod + PROD_W'(job.ch));
		pair  = job.pairs[lvl_q];
		unique case (phase_q)
			PH_MIN: begin
				res_addr  = a_min;
				res_value = pair.lo;
				res_last  = 1'b0;
			end
			PH_MAX: begin
				res_addr  = amin_q + ADDR_W'(cfg.chans);
				res_value = pair.hi;
				res_last  = is_last;
			end
			default: begin
				res_addr  = a_min;
				res_value = pair.lo;
				res_last  = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_MIN;
			lvl_q       <= '0;
			out_valid_q <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			lvl_q       <= lvl_d;
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			address_q <= res_addr;
			value_q   <= res_value;
			last_q    <= res_last;
			if (phase_q == PH_MIN)
				amin_q <= a_min;
		end
	end

	a_level_in_job: assert property (@(posedge clk) disable iff (!arst_n)
		job_valid |-> (LVL_W'(lvl_q) < job.count))
		else $error("level index past closed levels of job");

	a_pop_on_max: assert property (@(posedge clk) disable iff (!arst_n)
		job_pop |-> (phase_q == PH_MAX))
		else $error("job released before its last maximum");

	a_min_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		step && (phase_q == PH_MIN) |=> (phase_q == PH_MAX) && !last_q)
		else $error("minimum beat flagged last or phase not advanced");

endmodule

// File: tb/min_max_envelope_pyramid_tb.sv
// Self-checking testbench for the min/max envelope pyramid, directed and random sample streams.
`timescale 1ns / 1ps

module min_max_envelope_pyramid_tb;
	import mmep_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	// extra settle time on top of the block's path to its first result beat
	localparam int SETTLE_CYCLES = 8;
	localparam int RANDOM_ITEMS  = 110;
	localparam int WIDE_ITEMS    = 70;

	// one min or max bound as it should leave the block
	typedef struct {
		logic [ADDR_W-1:0] address;
		sample_t           value;
		logic              last_of_run;
	} bound_beat_t;

	// Tracks the running block bounds of every channel and level and holds the
	// bound beats still owed by the block, oldest first.
	class envelope_tracker;
		logic [CFG_W-1:0] chan_reg;
		logic [LG_W-1:0]  len_reg;
		sample_t          run_min [MAX_CHANNELS][LEVELS];
		sample_t          run_max [MAX_CHANNELS][LEVELS];
		int unsigned      column_pos;
		int unsigned      channel_pos;
		bound_beat_t      expected_bounds [$];
		int               errors;

		function new();
			chan_reg = RST_CHANNEL_COUNT;
			len_reg  = RST_LOG2_LENGTH;
			errors   = 0;
			restart_stream();
		endfunction

		// empty accumulators, stream position back to column 0, channel 0
		function void restart_stream();
			for (int c = 0; c < MAX_CHANNELS; c++)
				for (int l = 0; l < LEVELS; l++) begin
					run_min[c][l] = 32'sh7FFF_FFFF;
					run_max[c][l] = 32'sh8000_0000;
				end
			column_pos  = 0;
			channel_pos = 0;
		endfunction

		function int unsigned channels_in_use();
			if (chan_reg == '0)
				return 1;
			if (chan_reg > CFG_W'(MAX_CHANNELS))
				return MAX_CHANNELS;
			return chan_reg;
		endfunction

		function int unsigned length_log2();
			if (len_reg < LG_W'(2))
				return 2;
			if (len_reg > LG_W'(MAX_LOG2_LENGTH))
				return MAX_LOG2_LENGTH;
			return len_reg;
		endfunction

		function void write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] data);
			if (index == REG_CHANNEL_COUNT)
				chan_reg = data;
			else if (index == REG_LOG2_LENGTH)
				len_reg = data[LG_W-1:0];
			restart_stream();
		endfunction

		// fold one sample into every level of its channel; queue the bounds of closed blocks
		function void accept_sample(sample_t s);
			int unsigned chans, lg, n, ch, col, mask, start, pcol, base;
			bound_beat_t run [$];
			bound_beat_t b;
			chans = channels_in_use();
			lg    = length_log2();
			n     = 1 << lg;
			ch    = (channel_pos >= chans) ? 0 : channel_pos;
			col   = (column_pos >= n) ? 0 : column_pos;
			for (int j = 1; j < lg; j++) begin
				if (s < run_min[ch][j-1])
					run_min[ch][j-1] = s;
				if (s > run_max[ch][j-1])
					run_max[ch][j-1] = s;
				mask = (1 << j) - 1;
				if ((col & mask) == mask) begin
					// level j starts at column 2N - 4N/2^j, min and max columns interleaved
					start         = 2 * n - ((4 * n) >> j);
					pcol          = start + 2 * (col >> j);
					base          = pcol * chans + ch;
					b.address     = ADDR_W'(base);
					b.value       = run_min[ch][j-1];
					b.last_of_run = 1'b0;
					run.push_back(b);
					b.address     = ADDR_W'(base + chans);
					b.value       = run_max[ch][j-1];
					run.push_back(b);
					run_min[ch][j-1] = 32'sh7FFF_FFFF;
					run_max[ch][j-1] = 32'sh8000_0000;
				end
			end
			foreach (run[i]) begin
				b             = run[i];
				b.last_of_run = (i == run.size() - 1);
				expected_bounds.push_back(b);
			end
			ch++;
			if (ch >= chans) begin
				ch = 0;
				col++;
				if (col >= n)
					col = 0;
			end
			channel_pos = ch;
			column_pos  = col;
		endfunction

		function void compare_beat(logic [ADDR_W-1:0] got_address, sample_t got_value,
				logic got_last);
			bound_beat_t want;
			if (expected_bounds.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat: address %0d value %0d last_of_run %0b",
					$time, got_address, got_value, got_last);
				return;
			end
			want = expected_bounds.pop_front();
			if (got_address !== want.address) begin
				errors++;
				$display("%0t: address expected %0d actual %0d", $time, want.address,
					got_address);
			end
			if (got_value !== want.value) begin
				errors++;
				$display("%0t: value expected %0d actual %0d (address %0d)", $time,
					want.value, got_value, want.address);
			end
			if (got_last !== want.last_of_run) begin
				errors++;
				$display("%0t: last_of_run expected %0b actual %0b (address %0d)", $time,
					want.last_of_run, got_last, want.address);
			end
		endfunction

		function int pending();
			return expected_bounds.size();
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n       = 1'b0;
	logic                 push         = 1'b0;
	logic                 full;
	sample_t              sample       = '0;
	logic                 empty;
	logic                 pop          = 1'b0;
	logic [ADDR_W-1:0]    address;
	sample_t              value;
	logic                 last_of_run;
	logic                 write_enable = 1'b0;
	logic [CFG_IDX_W-1:0] reg_index    = REG_CHANNEL_COUNT;
	logic [CFG_W-1:0]     write_data   = '0;

	// longest gap each side may draw before its next beat; 0 gives a stretch with no idling
	int                   send_idle_max = 0;
	int                   recv_idle_max = 0;
	int unsigned          cycle_count   = 0;
	envelope_tracker      envelope;

	min_max_envelope_pyramid i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.sample       (sample),
		.empty        (empty),
		.pop          (pop),
		.address      (address),
		.value        (value),
		.last_of_run  (last_of_run),
		.write_enable (write_enable),
		.reg_index    (reg_index),
		.write_data   (write_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: end the run if it hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// Sample both handshakes at the edge where they complete. Signals read here still
	// hold their pre-edge values, so the beat seen is the beat taken by the block.
	// Note the input first: a result can never belong to a sample of the same edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full)
				envelope.accept_sample(sample);
			if (pop && !empty)
				envelope.compare_beat(address, value, last_of_run);
		end
	end

	function automatic int draw_idle_max();
		return ($urandom_range(0, 2) == 0) ? 0 : 6;
	endfunction

	// corner values of the sample range for the directed streams
	function automatic sample_t edge_sample(int i);
		case (i % 8)
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'sh0000_0000;
			3: return 32'shFFFF_FFFF;
			4: return 32'sh0000_0001;
			5: return 32'sh8000_0000;
			6: return 32'sh7FFF_FFFF;
			default: return 32'sh0000_0000;
		endcase
	endfunction

	// mostly full-range values, with extremes and a cluster near zero so that ties occur
	function automatic sample_t random_sample();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return sample_t'($signed($urandom_range(0, 16)) - 8);
			default: return sample_t'($urandom);
		endcase
	endfunction

	// Offer one sample and return at the edge that takes it. Push is left high so a
	// back-to-back sample keeps it high; it only drops when a gap is drawn.
	task automatic send_sample(input sample_t s);
		int gap;
		gap = $urandom_range(0, send_idle_max);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push   <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (full)
			@(posedge clk);
	endtask

	// Hold the sender until every owed bound has come out, then let the block go quiet.
	// The first edge makes sure a sample taken at the calling edge is already noted.
	task automatic wait_drained();
		push <= 1'b0;
		@(posedge clk);
		while (envelope.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write both registers on back-to-back edges; each write restarts the stream.
	task automatic reconfigure(input logic [CFG_W-1:0] chans_data,
			input logic [CFG_W-1:0] lg_data);
		wait_drained();
		write_enable <= 1'b1;
		reg_index    <= REG_CHANNEL_COUNT;
		write_data   <= chans_data;
		@(posedge clk);
		reg_index    <= REG_LOG2_LENGTH;
		write_data   <= lg_data;
		@(posedge clk);
		write_enable <= 1'b0;
		envelope.write_register(REG_CHANNEL_COUNT, chans_data);
		envelope.write_register(REG_LOG2_LENGTH, lg_data);
	endtask

	// Result side: pop with a freshly drawn stall before every beat.
	initial begin : result_drain
		int gap;
		wait (arst_n);
		forever begin
			gap = $urandom_range(0, recv_idle_max);
			if (gap > 0) begin
				pop <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty)
				@(posedge clk);
		end
	end

	initial begin : stimulus
		int               total;
		int               phase_len;
		int               pause_at;
		logic [CFG_W-1:0] chans_data;
		logic [LG_W-1:0]  lg_low;
		logic [CFG_W-1:0] lg_data;
		envelope = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: reset settings (one channel, 1024 columns); eight corner samples
		// close level 1 four times, level 2 twice and level 3 once.
		send_idle_max = 6;
		recv_idle_max = 3;
		for (int i = 0; i < 8; i++)
			send_sample(edge_sample(i));

		// Zero channels and a length below the floor: one channel, four columns.
		// Six samples run past the end of the frame and into the next one.
		reconfigure(7'd0, 7'd1);
		for (int i = 0; i < 6; i++)
			send_sample(edge_sample(i + 2));

		// Channel count above the ceiling, length at the ceiling: no block closes.
		reconfigure(7'd127, 7'd16);
		for (int i = 0; i < 6; i++)
			send_sample(edge_sample(i));

		// All ones on the length write: upper bits drop, the rest is above the ceiling.
		reconfigure(7'd2, 7'h7F);
		for (int i = 0; i < 4; i++)
			send_sample(edge_sample(i + 4));

		// Random: the full channel count on the shortest frame, so the widest addresses
		// of level 1 come out once column 1 is reached. Drain once after column 0.
		total = 0;
		send_idle_max = draw_idle_max();
		recv_idle_max = draw_idle_max();
		reconfigure(7'd64, 7'd2);
		for (int i = 0; i < WIDE_ITEMS; i++) begin
			if (i == MAX_CHANNELS)
				wait_drained();
			send_sample(random_sample());
			total++;
		end

		// Random phases: mostly few channels and short frames so that blocks close
		// often, now and then a clamped or long setting.
		while (total < RANDOM_ITEMS) begin
			case ($urandom_range(0, 7))
				0: chans_data = 7'd0;
				1: chans_data = CFG_W'($urandom_range(64, 127));
				default: chans_data = CFG_W'($urandom_range(1, 4));
			endcase
			case ($urandom_range(0, 7))
				0: lg_low = LG_W'($urandom_range(0, 1));
				1: lg_low = LG_W'($urandom_range(6, 31));
				default: lg_low = LG_W'($urandom_range(2, 5));
			endcase
			lg_data       = {2'($urandom_range(0, 3)), lg_low};
			send_idle_max = draw_idle_max();
			recv_idle_max = draw_idle_max();
			phase_len     = $urandom_range(6, 20);
			pause_at      = $urandom_range(1, 2 * phase_len);
			reconfigure(chans_data, lg_data);
			for (int i = 0; i < phase_len; i++) begin
				if (i == pause_at)
					wait_drained();
				send_sample(random_sample());
				total++;
			end
		end

		wait_drained();
		repeat (20) @(posedge clk);
		if (envelope.errors == 0 && envelope.pending() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
